// ----- design/oneshot_ms_timer_assert.svh -----
// assertion macros shared by the timer checker
`ifndef ONESHOT_MS_TIMER_ASSERT_SVH
`define ONESHOT_MS_TIMER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define OMT_ASSERT(lbl, clk_e, rst_e, prop, msg) \
  lbl: assert property (@(posedge clk_e) disable iff (rst_e) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OMT_ASSERT_NEXT(lbl, clk_e, rst_e, ante, cons, msg) \
  lbl: assert property (@(posedge clk_e) disable iff (rst_e) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/omt_pkg.sv -----
// types, widths and constants of the one-shot millisecond timer
package omt_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CLK_W      = 20;
  localparam int MS_W       = 32;
  localparam int ACT_W      = 2;
  localparam int NOW_W      = 26;
  // ticks * 1000 always fits, since 1000 < 1024
  localparam int PROD_W     = COUNT_BITS + 10;
  localparam int OPA_W      = (PROD_W > MS_W) ? PROD_W : MS_W;
  localparam int STEP_MAX   = (PROD_W > CLK_W) ? PROD_W : CLK_W;
  localparam int CNT_W      = $clog2(STEP_MAX + 1);
  localparam int S_TDATA_W  = ((MS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((NOW_W + 7) / 8) * 8;

  localparam logic [CLK_W-1:0]  CLK_RESET  = CLK_W'(32768);
  localparam logic [PROD_W-1:0] TICK_LIMIT =
    PROD_W'(((64'd1 << COUNT_BITS) - 64'd1) * 64'd1000);
  localparam logic [NOW_W-1:0]  NOW_MAX    = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } unit_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NSTART,
    ST_NDIV,
    ST_EMIT
  } state_t;

endpackage

// ----- design/omt_unit.sv -----
// shared bit-serial multiply / restoring divide unit
module omt_unit import omt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  unit_req_t         req,
  input  logic [OPA_W-1:0]  opa,
  input  logic [CLK_W-1:0]  opb,
  output unit_rsp_t         rsp,
  output logic [PROD_W-1:0] result
);

  localparam int SUM_W = ((PROD_W + 1 > OPA_W) ? PROD_W + 1 : OPA_W) + 1;

  logic              busy;
  logic              done;
  logic              ovf;
  unit_op_t          op_q;
  logic [CNT_W-1:0]  cnt;
  logic [OPA_W-1:0]  mcand;
  logic [CLK_W-1:0]  mplier;
  logic [PROD_W-1:0] acc;
  logic [CLK_W-1:0]  rem;

  logic [SUM_W-1:0]  mul_sum;
  logic [CLK_W:0]    rem_sh;
  logic [CLK_W:0]    diff;
  logic              ge;

  // multiply walks the multiplier from its msb: acc = 2*acc + bit*mcand
  assign mul_sum = SUM_W'({acc, 1'b0}) + (mplier[CLK_W-1] ? SUM_W'(mcand) : '0);
  assign rem_sh  = {rem, acc[PROD_W-1]};
  assign diff    = rem_sh - {1'b0, mplier};
  assign ge      = rem_sh >= {1'b0, mplier};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == OP_MUL) ? CNT_W'(CLK_W) : CNT_W'(PROD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_q   <= req.op;
      mcand  <= opa;
      mplier <= opb;
      rem    <= '0;
      ovf    <= 1'b0;
      acc    <= (req.op == OP_MUL) ? '0 : opa[PROD_W-1:0];
    end else if (busy) begin
      unique case (op_q)
        OP_MUL: begin
          acc    <= mul_sum[PROD_W-1:0];
          ovf    <= ovf | (|mul_sum[SUM_W-1:PROD_W]);
          mplier <= mplier << 1;
        end
        OP_DIV: begin
          rem <= ge ? diff[CLK_W-1:0] : rem_sh[CLK_W-1:0];
          acc <= {acc[PROD_W-2:0], ge};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign result   = acc;

endmodule

// ----- design/oneshot_ms_timer.sv -----
// one-shot timer with millisecond conversion, top level
//
//  group   dir  signals                     beat content
//  cfg     in   cfg_wr_en, cfg_wr_data      tick_hz
//  s_*     in   tvalid, tready, tdata/tuser action, timeout_value_ms
//  m_*     out  tvalid, tready, tdata/tuser status, now_ms, expired
//
// one item at a time; the serial unit sets the pace, from input beat to result beat loaded:
//   start past the zero checks: the multiply, then the now divide, then the result beat
//   tick, stop, other actions, zero timeout: the now divide, then the result; with tick_hz zero: the result
// the next input beat is taken once the result beat is loaded, unless an earlier result is still stalled
// rst clears the sequencer, the timer state and tick_hz to 32768; no clearing pass
module oneshot_ms_timer import omt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CLK_W-1:0]     cfg_wr_data,  // tick_hz
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,      // timeout_value_ms
  input  logic [ACT_W-1:0]     s_tuser,      // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,      // now_ms, zero padding
  output logic [1:0]           m_tuser       // status, expired
);

  state_t                state;
  state_t                state_next;
  logic [CLK_W-1:0]      tick_hz;
  logic [COUNT_BITS-1:0] running_count;
  logic [PROD_W-1:0]     target_scaled;
  logic [COUNT_BITS-1:0] done_ticks;
  logic                  armed;
  logic                  status_q;
  logic                  expired_q;
  logic [NOW_W-1:0]      now_q;

  unit_req_t             req;
  unit_rsp_t             rsp;
  logic [OPA_W-1:0]      opa;
  logic [CLK_W-1:0]      opb;
  logic [PROD_W-1:0]     result;

  logic                  accept;
  action_t               in_act;
  logic [MS_W-1:0]       in_ms;
  logic                  start_ok;
  logic                  mul_bad;
  logic                  out_free;
  logic [COUNT_BITS-1:0] run_inc;
  logic [PROD_W-1:0]     run_k;
  logic                  run_hit;
  logic [COUNT_BITS-1:0] sel_ticks;
  logic [PROD_W-1:0]     ticks_k;
  logic [NOW_W-1:0]      now_sat;

  assign accept   = s_tvalid & s_tready;
  assign in_act   = action_t'(s_tuser);
  assign in_ms    = s_tdata[MS_W-1:0];
  assign start_ok = (in_act == ACT_START) && (in_ms != '0) && (tick_hz != '0);
  assign mul_bad  = rsp.ovf || (result > TICK_LIMIT);
  assign out_free = !m_tvalid || m_tready;
  assign run_inc  = running_count + COUNT_BITS'(1);

  // target kept as hz * ms; the tick count is its ceiling over 1000, reached
  // at the first count whose 1000 multiple covers it
  assign run_k   = PROD_W'({run_inc, 10'b0}) - PROD_W'({run_inc, 4'b0})
                 - PROD_W'({run_inc, 3'b0});
  assign run_hit = run_k >= target_scaled;

  // elapsed ticks, or the live count while running with nothing latched
  assign sel_ticks = (done_ticks != '0) ? done_ticks : (armed ? running_count : '0);
  assign ticks_k   = PROD_W'({sel_ticks, 10'b0}) - PROD_W'({sel_ticks, 4'b0})
                   - PROD_W'({sel_ticks, 3'b0});
  assign now_sat   = (result > PROD_W'(NOW_MAX)) ? NOW_MAX : NOW_W'(result);

  omt_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .rsp    (rsp),
    .result (result)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = start_ok ? ST_MUL : ST_NSTART;
      end
      ST_MUL: begin
        if (rsp.done) state_next = ST_NSTART;
      end
      ST_NSTART: begin
        state_next = (tick_hz == '0) ? ST_EMIT : ST_NDIV;
      end
      ST_NDIV: begin
        if (rsp.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    req.start = 1'b0;
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept && start_ok) begin
          req.start = 1'b1;
          opa       = OPA_W'(in_ms);
          opb       = tick_hz;
        end
      end
      ST_NSTART: begin
        if (tick_hz != '0) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          opa       = OPA_W'(ticks_k);
          opb       = tick_hz;
        end
      end
      ST_MUL, ST_NDIV, ST_EMIT: begin
        s_tready = 1'b0;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tick_hz       <= CLK_RESET;
      running_count <= '0;
      target_scaled <= '0;
      done_ticks    <= '0;
      armed         <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) tick_hz <= cfg_wr_data;

      if (state == ST_IDLE && accept && in_act == ACT_TICK && armed) begin
        running_count <= run_inc;
        if (run_hit) begin
          done_ticks <= run_inc;
          armed      <= 1'b0;
        end
      end else if (state == ST_IDLE && accept && in_act == ACT_STOP) begin
        armed <= 1'b0;
      end else if (state == ST_MUL && rsp.done && !mul_bad) begin
        target_scaled <= result;
        running_count <= '0;
        done_ticks    <= '0;
        armed         <= 1'b1;
      end

      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // per-beat payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      status_q  <= (in_act == ACT_START) && !start_ok;
      expired_q <= (in_act == ACT_TICK) && armed && run_hit;
    end else if (state == ST_MUL && rsp.done && mul_bad) begin
      status_q <= 1'b1;
    end
    if (state == ST_NSTART && tick_hz == '0) begin
      now_q <= '0;
    end else if (state == ST_NDIV && rsp.done) begin
      now_q <= now_sat;
    end
    if (state == ST_EMIT && out_free) begin
      m_tdata <= M_TDATA_W'(now_q);
      m_tuser <= {expired_q, status_q};
    end
  end

endmodule

// ----- design/omt_checker.sv -----
// port-level checks for the one-shot timer, bound to the top level
`include "oneshot_ms_timer_assert.svh"

module omt_checker import omt_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [1:0]           m_tuser
);

  // stalled result beat holds
  `OMT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // a rejected start never reports an expiry
  `OMT_ASSERT(a_flags_excl, clk, rst, !m_tvalid || !(m_tuser[0] && m_tuser[1]), "status and expired both set")

  // the block works on one item at a time
  `OMT_ASSERT_NEXT(a_busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready, "input taken again right after a beat")

  // padding above now_ms stays zero
  `OMT_ASSERT(a_pad_zero, clk, rst, !m_tvalid || ((m_tdata >> NOW_W) == '0), "nonzero padding in result")

endmodule

bind oneshot_ms_timer omt_checker u_omt_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for the one-shot millisecond timer
`timescale 1ns / 1ps

module tb_top;
  import omt_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam longint      COUNT_TOP   = (64'd1 << COUNT_BITS) - 64'd1;

  typedef struct packed {
    logic             status;
    logic [NOW_W-1:0] now_ms;
    logic             expired;
  } reading_t;

  typedef struct packed {
    logic             is_cfg;
    action_t          act;
    logic [MS_W-1:0]  val;
    logic             typed;
    reading_t         want;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CLK_W-1:0]     cfg_wr_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;     // timeout_value_ms
  logic [ACT_W-1:0]     s_tuser = '0;     // action
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;          // now_ms, zero padding
  logic [1:0]           m_tuser;          // status, expired

  oneshot_ms_timer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // timer model state
  logic [CLK_W-1:0]      hz_setting = CLK_RESET;
  logic [COUNT_BITS-1:0] tick_count = '0;
  logic [COUNT_BITS-1:0] goal_ticks = '0;
  logic [COUNT_BITS-1:0] latched_ticks = '0;
  logic                  timer_armed = 1'b0;

  reading_t due_readings[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       stall_left = 0;
  bit       no_gaps = 1'b0;
  reading_t got_want;

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic reading_t advance_timer(input action_t act, input logic [MS_W-1:0] ms);
    reading_t        r;
    longint unsigned goal;
    longint unsigned shown;
    r = '0;
    case (act)
      ACT_TICK: begin
        if (timer_armed) begin
          tick_count = tick_count + 1'b1;
          if (tick_count == goal_ticks) begin
            latched_ticks = goal_ticks;
            timer_armed   = 1'b0;
            r.expired     = 1'b1;
          end
        end
      end
      ACT_START: begin
        if (ms == '0 || hz_setting == '0) begin
          r.status = 1'b1;
        end else begin
          // ceil(hz * ms / 1000)
          goal = 64'(hz_setting);
          goal = (goal * ms + 64'd999) / 64'd1000;
          if (goal > COUNT_TOP) begin
            r.status = 1'b1;
          end else begin
            goal_ticks    = goal[COUNT_BITS-1:0];
            tick_count    = '0;
            latched_ticks = '0;
            timer_armed   = 1'b1;
          end
        end
      end
      ACT_STOP: timer_armed = 1'b0;
      default: ;
    endcase
    shown = 64'(latched_ticks);
    if (shown == 64'd0 && timer_armed) shown = 64'(tick_count);
    if (hz_setting == '0) shown = 64'd0;
    else shown = shown * 64'd1000 / hz_setting;
    if (shown > NOW_MAX) shown = NOW_MAX;
    r.now_ms = shown[NOW_W-1:0];
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint exp);
    if (mismatches < 50) $display("MISMATCH %s: got %0d expected %0d", what, got, exp);
    mismatches++;
  endtask

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(input action_t act, input logic [MS_W-1:0] ms,
                           input logic fixed = 1'b0, input reading_t fixed_val = '0);
    int       gap;
    reading_t r;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= ms;
    do @(posedge clk); while (!s_tready);
    r = advance_timer(act, ms);
    due_readings.push_back(fixed ? fixed_val : r);
    @(negedge clk);
  endtask

  task automatic release_bus();
    s_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (due_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] hz);
    release_bus();
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    hz_setting = hz;
  endtask

  task automatic run_random(input int quota);
    int              counted;
    int              target;
    int              runs;
    int              k;
    int              pick;
    action_t         act;
    logic [MS_W-1:0] ms;
    counted = 0;
    while (counted < quota) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        // start aimed at a short count, then a run of ticks around it
        target = $urandom_range(1, 24);
        if (hz_setting == '0) ms = $urandom_range(1, 100);
        else ms = (target * 1000) / hz_setting;
        if (ms == '0) ms = 1;
        send_item(ACT_START, ms);
        runs = $urandom_range(0, target + 3);
        for (k = 0; k < runs; k++) begin
          pick = $urandom_range(0, 29);
          if (pick == 0) send_item(ACT_STOP, $urandom);
          else if (pick == 1) send_item(ACT_START, ms);
          else send_item(ACT_TICK, $urandom);
        end
        counted += runs + 1;
      end else if (pick < 84) begin
        case ($urandom_range(0, 3))
          0: ms = '0;
          1: ms = $urandom;
          2: ms = (hz_setting == '0) ? $urandom : 65535000 / hz_setting;
          default: ms = (hz_setting == '0) ? $urandom : 65535000 / hz_setting + 1;
        endcase
        send_item(ACT_START, ms);
        counted++;
      end else if (pick < 97) begin
        act = action_t'($urandom_range(0, 3));
        send_item(act, $urandom);
        if (act != ACT_NONE) counted++;
      end else begin
        // hold off until the block has caught up
        release_bus();
        drain_results();
      end
    end
  endtask

  step_row_t plan [0:32] = '{
    '{1'b0, ACT_TICK,  32'd0,        1'b1, '{1'b0, 26'd0,    1'b0}},
    '{1'b0, ACT_STOP,  32'd0,        1'b1, '{1'b0, 26'd0,    1'b0}},
    '{1'b0, ACT_NONE,  32'hffffffff, 1'b1, '{1'b0, 26'd0,    1'b0}},
    '{1'b0, ACT_START, 32'd0,        1'b1, '{1'b1, 26'd0,    1'b0}},
    '{1'b0, ACT_START, 32'hffffffff, 1'b1, '{1'b1, 26'd0,    1'b0}},
    '{1'b0, ACT_START, 32'd2000,     1'b1, '{1'b1, 26'd0,    1'b0}},
    '{1'b0, ACT_START, 32'd1999,     1'b0, '0},
    '{1'b0, ACT_TICK,  32'd0,        1'b0, '0},
    '{1'b1, ACT_TICK,  32'd1000,     1'b0, '0},
    '{1'b0, ACT_START, 32'd3,        1'b0, '0},
    '{1'b0, ACT_TICK,  32'd7,        1'b0, '0},
    '{1'b0, ACT_TICK,  32'd0,        1'b0, '0},
    '{1'b0, ACT_START, 32'd2,        1'b0, '0},  // restart while armed
    '{1'b0, ACT_TICK,  32'd0,        1'b0, '0},
    '{1'b0, ACT_TICK,  32'd0,        1'b0, '0},  // expires
    '{1'b0, ACT_TICK,  32'd0,        1'b0, '0},
    '{1'b0, ACT_STOP,  32'd0,        1'b0, '0},
    '{1'b0, ACT_START, 32'd5,        1'b0, '0},
    '{1'b0, ACT_TICK,  32'd0,        1'b0, '0},
    '{1'b0, ACT_STOP,  32'd0,        1'b0, '0},
    '{1'b0, ACT_TICK,  32'd0,        1'b0, '0},
    '{1'b1, ACT_TICK,  32'd0,        1'b0, '0},
    '{1'b0, ACT_START, 32'd5,        1'b1, '{1'b1, 26'd0,    1'b0}},
    '{1'b0, ACT_TICK,  32'd0,        1'b1, '{1'b0, 26'd0,    1'b0}},
    '{1'b1, ACT_TICK,  32'd1000000,  1'b0, '0},
    '{1'b0, ACT_START, 32'd65,       1'b0, '0},
    '{1'b0, ACT_START, 32'd66,       1'b1, '{1'b1, 26'd0,    1'b0}},
    '{1'b0, ACT_TICK,  32'd0,        1'b0, '0},
    '{1'b1, ACT_TICK,  32'd1,        1'b0, '0},
    '{1'b0, ACT_START, 32'd1,        1'b0, '0},
    '{1'b0, ACT_TICK,  32'd0,        1'b1, '{1'b0, 26'd1000, 1'b1}},
    '{1'b0, ACT_START, 32'd65535000, 1'b0, '0},
    '{1'b0, ACT_START, 32'd65535001, 1'b1, '{1'b1, 26'd0,    1'b0}}
  };

  // result side: check on the rising edge, drive tready on the falling edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_readings.size() == 0) begin
        report("result with nothing pending, now_ms", m_tdata, 0);
      end else begin
        got_want = due_readings.pop_front();
        if (m_tuser[0] !== got_want.status) report("status", m_tuser[0], got_want.status);
        if (m_tdata !== M_TDATA_W'(got_want.now_ms))
          report("now_ms", m_tdata, got_want.now_ms);
        if (m_tuser[1] !== got_want.expired) report("expired", m_tuser[1], got_want.expired);
      end
      stall_left = draw_gap();
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_clock(plan[i].val[CLK_W-1:0]);
      else send_item(plan[i].act, plan[i].val, plan[i].typed, plan[i].want);
    end

    write_clock(20'd1000);
    run_random(250);
    write_clock(20'd1);
    run_random(200);
    write_clock(20'd0);
    run_random(80);
    write_clock(20'd1000000);
    run_random(120);
    write_clock(20'd524287);
    run_random(100);
    write_clock(CLK_W'($urandom_range(2, 2000)));
    run_random(200);
    write_clock(CLK_W'($urandom_range(2, 2000)));
    run_random(200);
    write_clock(CLK_W'($urandom_range(0, 1000000)));
    run_random(150);
    write_clock(CLK_RESET);
    run_random(150);

    release_bus();
    while (due_readings.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- oneshot_ms_timer.f -----
+incdir+design
design/omt_pkg.sv
design/omt_unit.sv
design/oneshot_ms_timer.sv
design/omt_checker.sv
tb/tb_top.sv
